### design/spl_pkg.sv
package spl_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REKEY  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_WALK   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LISTED     = 2'd1;
    localparam logic [1:0] ST_NOT_LISTED = 2'd2;

    localparam logic [1:0] MODE_ASC  = 2'd0;
    localparam logic [1:0] MODE_DESC = 2'd1;
    localparam logic [1:0] MODE_EQ   = 2'd2;

    localparam logic REG_COMPARE_MODE = 1'b0;
    localparam logic REG_TIE_FIRST    = 1'b1;

    localparam int SLOT_W = 5;
    localparam int KEY_W  = 32;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [1:0]        status;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic              valid;
        logic              last;
    } res_t;

    // true when the scan passes over an entry with key cur for new key nk
    function automatic logic scan_skips(input logic [KEY_W-1:0] nk,
                                        input logic [KEY_W-1:0] cur,
                                        input logic [1:0] mode,
                                        input logic tie);
        logic gt;
        logic lt;
        gt = $signed(nk) > $signed(cur);
        lt = $signed(nk) < $signed(cur);
        if (mode == MODE_ASC && gt)
            return 1'b1;
        if (mode == MODE_DESC && lt)
            return 1'b1;
        if (nk != cur && mode != MODE_EQ)
            return 1'b0;
        return !tie;
    endfunction

endpackage

### design/spl_front.sv
module spl_front #(
    parameter int SLOTS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                operation,
    input  logic [spl_pkg::SLOT_W-1:0] node_slot,
    input  logic [spl_pkg::KEY_W-1:0] order_key,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output spl_pkg::cmd_t             cmd,
    input  logic                      clr_listed,
    input  logic                      set_listed,
    input  logic                      drop_listed,
    input  logic [spl_pkg::SLOT_W-1:0] upd_slot
);
    import spl_pkg::*;

    localparam int QD = 2;

    logic [SLOTS-1:0] listed_reg;
    logic [SLOTS-1:0] listed_next;
    cmd_t             q_reg [QD];
    logic [1:0]       cnt_reg;
    logic             rd_reg;
    logic             wr_reg;
    logic             busy_reg;
    logic             busy_next;
    logic             push;
    logic             pop;
    logic             in_range;
    logic             listed;
    cmd_t             c;

    // one command in flight at a time; listed marks follow the back part
    assign in_ready  = !busy_reg && cnt_reg < 2'(QD);
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_reg];

    assign in_range = 32'(node_slot) < SLOTS;
    assign listed   = in_range && listed_reg[node_slot[$clog2(SLOTS)-1:0]];

    always_comb
    begin
        c.op     = operation;
        c.slot   = node_slot;
        c.key    = order_key;
        c.status = ST_OK;
        case (operation)
            OP_INSERT:
            begin
                if (!in_range)
                    c.status = ST_NOT_LISTED;
                else if (listed)
                    c.status = ST_LISTED;
            end
            OP_REKEY, OP_REMOVE:
            begin
                if (!listed)
                    c.status = ST_NOT_LISTED;
            end
            default: c.status = ST_OK;
        endcase
    end

    always_comb
    begin
        listed_next = listed_reg;
        if (clr_listed)
            listed_next = '0;
        if (set_listed)
            listed_next[upd_slot[$clog2(SLOTS)-1:0]] = 1'b1;
        if (drop_listed)
            listed_next[upd_slot[$clog2(SLOTS)-1:0]] = 1'b0;
        busy_next = busy_reg;
        if (push)
            busy_next = 1'b1;
        if (clr_listed || set_listed || drop_listed || pop && cmd.status != ST_OK
            || pop && cmd.op != OP_INSERT && cmd.op != OP_REKEY
               && cmd.op != OP_REMOVE && cmd.op != OP_CLEAR)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listed_reg <= '0;
            cnt_reg    <= '0;
            rd_reg     <= 1'b0;
            wr_reg     <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            listed_reg <= listed_next;
            busy_reg   <= busy_next;
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= c;
    end

endmodule

### design/spl_back.sv
module spl_back #(
    parameter int SLOTS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  spl_pkg::cmd_t  cmd,
    input  logic [1:0]     compare_mode,
    input  logic           tie_first,
    output logic           res_valid,
    input  logic           res_ready,
    output spl_pkg::res_t  res,
    output logic           clr_listed,
    output logic           set_listed,
    output logic           drop_listed,
    output logic [spl_pkg::SLOT_W-1:0] upd_slot
);
    import spl_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RFIND  = 8'b0000_0010,
        S_RSHIFT = 8'b0000_0100,
        S_IFIND  = 8'b0000_1000,
        S_ISHIFT = 8'b0001_0000,
        S_WALK   = 8'b0010_0000,
        S_WKEY   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    logic [SLOT_W-1:0] pos_mem [SLOTS];
    logic [KEY_W-1:0]  key_mem [SLOTS];

    state_t            state_reg;
    state_t            state_next;
    cmd_t              cur_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    logic [CW-1:0]     ins_reg;
    logic [CW-1:0]     ins_next;
    logic [SLOT_W-1:0] pos_rd_reg;
    logic [AW-1:0]     ra_reg;
    logic              pend_reg;
    logic              pend_next;
    logic              rval_reg;
    logic              rval_next;
    res_t              r_reg;
    res_t              r_next;
    logic              pos_we;
    logic [AW-1:0]     pos_wa;
    logic [SLOT_W-1:0] pos_wd;
    logic [AW-1:0]     pos_ra;
    logic              key_we;
    logic [AW-1:0]     key_ra;
    logic [KEY_W-1:0]  key_rd_reg;
    logic              out_free;

    assign res_valid = rval_reg;
    assign res       = r_reg;
    assign out_free  = !rval_reg || res_ready;
    assign cmd_ready = state_reg == S_IDLE;

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        pos_rd_reg <= pos_mem[pos_ra];
        if (key_we)
            key_mem[cur_reg.slot[AW-1:0]] <= cur_reg.key;
        key_rd_reg <= key_mem[key_ra];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ins_next    = ins_reg;
        pend_next   = 1'b0;
        rval_next   = rval_reg && !res_ready;
        r_next      = r_reg;
        pos_we      = 1'b0;
        pos_wa      = idx_reg[AW-1:0];
        pos_wd      = pos_rd_reg;
        // hold the last read address until a new one is issued
        pos_ra      = ra_reg;
        key_we      = 1'b0;
        key_ra      = pos_rd_reg[AW-1:0];
        clr_listed  = 1'b0;
        set_listed  = 1'b0;
        drop_listed = 1'b0;
        upd_slot    = cur_reg.slot;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                ins_next = '0;
                pos_ra   = '0;
                if (cmd_valid)
                begin
                    if (cmd.status != ST_OK)
                        state_next = S_OUT;
                    else
                    begin
                        case (cmd.op)
                            OP_INSERT: state_next = S_IFIND;
                            OP_REKEY, OP_REMOVE: state_next = S_RFIND;
                            OP_WALK: state_next = (count_reg == '0) ? S_OUT : S_WALK;
                            OP_CLEAR:
                            begin
                                count_next = '0;
                                clr_listed = 1'b1;
                                state_next = S_OUT;
                            end
                            default: state_next = S_OUT;
                        endcase
                    end
                    pend_next = 1'b1;
                end
            end
            S_RFIND:
            begin
                // pos_rd_reg holds entry idx_reg once pend is clear
                if (!pend_reg)
                begin
                    if (pos_rd_reg == cur_reg.slot)
                    begin
                        idx_next   = idx_reg;
                        state_next = S_RSHIFT;
                        pos_ra     = AW'(idx_reg + 1'b1);
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        pos_ra    = AW'(idx_reg + 1'b1);
                        pend_next = 1'b1;
                    end
                end
            end
            S_RSHIFT:
            begin
                // pull later entries up one place
                if (!pend_reg)
                begin
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        count_next  = count_reg - 1'b1;
                        if (cur_reg.op == OP_REMOVE)
                        begin
                            drop_listed = 1'b1;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            idx_next   = '0;
                            ins_next   = '0;
                            pos_ra     = '0;
                            pend_next  = 1'b1;
                            state_next = S_IFIND;
                        end
                    end
                    else
                    begin
                        pos_we    = 1'b1;
                        pos_wa    = idx_reg[AW-1:0];
                        idx_next  = idx_reg + 1'b1;
                        pos_ra    = AW'(idx_reg + 2'd2);
                        pend_next = 1'b1;
                    end
                end
            end
            S_IFIND:
            begin
                // first cycle writes the key; pos read then key read per entry
                key_we = idx_reg == '0 && pend_reg;
                if (idx_reg >= count_reg)
                begin
                    ins_next   = idx_reg;
                    idx_next   = count_reg;
                    pos_ra     = AW'(count_reg - 1'b1);
                    pend_next  = 1'b1;
                    state_next = S_ISHIFT;
                end
                else if (!pend_reg && !ins_reg[0])
                begin
                    ins_next = CW'(1);
                end
                else if (!pend_reg)
                begin
                    ins_next = '0;
                    if (scan_skips(cur_reg.key, key_rd_reg, compare_mode, tie_first))
                    begin
                        idx_next  = idx_reg + 1'b1;
                        pos_ra    = AW'(idx_reg + 1'b1);
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        ins_next   = idx_reg;
                        idx_next   = count_reg;
                        pos_ra     = AW'(count_reg - 1'b1);
                        pend_next  = 1'b1;
                        state_next = S_ISHIFT;
                    end
                end
            end
            S_ISHIFT:
            begin
                // move entries down one place from the tail to the gap
                if (!pend_reg)
                begin
                    pos_we = 1'b1;
                    pos_wa = idx_reg[AW-1:0];
                    if (idx_reg == ins_reg)
                    begin
                        pos_wd     = cur_reg.slot;
                        count_next = count_reg + 1'b1;
                        set_listed = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        pos_ra    = AW'(idx_reg - 2'd2);
                        pend_next = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                // pos_rd_reg valid; fetch its key
                if (!pend_reg)
                begin
                    pend_next  = 1'b1;
                    state_next = S_WKEY;
                end
            end
            S_WKEY:
            begin
                if (!pend_reg && out_free)
                begin
                    rval_next    = 1'b1;
                    r_next.status = ST_OK;
                    r_next.slot  = pos_rd_reg;
                    r_next.key   = key_rd_reg;
                    r_next.valid = 1'b1;
                    r_next.last  = idx_reg + 1'b1 >= count_reg;
                    if (idx_reg + 1'b1 >= count_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        pos_ra     = AW'(idx_reg + 1'b1);
                        pend_next  = 1'b1;
                        state_next = S_WALK;
                    end
                end
                else
                    key_ra = pos_rd_reg[AW-1:0];
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rval_next     = 1'b1;
                    r_next.status = cur_reg.status;
                    r_next.slot   = '0;
                    r_next.key    = '0;
                    r_next.valid  = 1'b0;
                    r_next.last   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            ins_reg   <= '0;
            ra_reg    <= '0;
            pend_reg  <= 1'b0;
            rval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ins_reg   <= ins_next;
            ra_reg    <= pos_ra;
            pend_reg  <= pend_next;
            rval_reg  <= rval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        if (state_reg == S_IDLE && cmd_valid)
            cur_reg <= cmd;
    end

endmodule

### design/sorted_priority_list.sv
// sorted_priority_list: ordered list of up to SLOTS slots with signed keys.
// Input channel (in_valid/in_ready) carries operation, node_slot, order_key.
// Output channel (out_valid/out_ready) carries status, out_slot, out_key,
// entry_valid and last; every input gives one result, except a walk of a
// non-empty list, which gives one result per entry in list order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// compare_mode (index 0) and tie_first (index 1); write only while idle.
// A front stage checks listed marks and queues commands; the back stage runs
// them one at a time against position and key memories, each with one write port and a registered read.
// Remove and insert step through the position memory one entry at a time over
// its single read port; re-key is a remove followed by an insert; a walk reads
// the position, then the key, of each entry before it gives that entry.
// Reset empties the list, unlists all slots and zeroes both registers.
// On a receiver stall the result holds in the output register and the back
// stage waits at its next result; the front takes at most one more transfer.
module sorted_priority_list #(
    parameter int SLOTS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 operation,
    input  logic [spl_pkg::SLOT_W-1:0] node_slot,
    input  logic signed [spl_pkg::KEY_W-1:0] order_key,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [spl_pkg::SLOT_W-1:0] out_slot,
    output logic signed [spl_pkg::KEY_W-1:0] out_key,
    output logic                       entry_valid,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [1:0]                 cfg_data
);
    import spl_pkg::*;

    logic [1:0]        mode_reg;
    logic              tie_reg;
    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;
    res_t              res;
    logic              clr_listed;
    logic              set_listed;
    logic              drop_listed;
    logic [SLOT_W-1:0] upd_slot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ASC;
            tie_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_COMPARE_MODE)
                mode_reg <= cfg_data;
            else
                tie_reg <= cfg_data[0];
        end
    end

    spl_front #(.SLOTS(SLOTS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .node_slot   (node_slot),
        .order_key   (order_key),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .clr_listed  (clr_listed),
        .set_listed  (set_listed),
        .drop_listed (drop_listed),
        .upd_slot    (upd_slot)
    );

    spl_back #(.SLOTS(SLOTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .compare_mode (mode_reg),
        .tie_first    (tie_reg),
        .res_valid    (out_valid),
        .res_ready    (out_ready),
        .res          (res),
        .clr_listed   (clr_listed),
        .set_listed   (set_listed),
        .drop_listed  (drop_listed),
        .upd_slot     (upd_slot)
    );

    assign status      = res.status;
    assign out_slot    = res.slot;
    assign out_key     = res.key;
    assign entry_valid = res.valid;
    assign last        = res.last;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res))
        else $error("result changed while stalled");

    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> status == ST_OK)
        else $error("walk entry with error status");

    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({clr_listed, set_listed, drop_listed}))
        else $error("conflicting listed mark updates");

endmodule

### sim/tb_sorted_priority_list.sv
`timescale 1ns / 100ps

module tb_sorted_priority_list;
    import spl_pkg::*;

    localparam int NUM_SLOTS = 32;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [31:0] key;
        logic        valid;
        logic        last;
    } list_result_t;

    class list_scoreboard;
        logic [4:0]  order_slots[NUM_SLOTS];
        logic [31:0] slot_keys[NUM_SLOTS];
        bit          listed[NUM_SLOTS];
        int          count;
        logic [1:0]  mode;
        logic        tie;
        list_result_t pending[$];
        int          errors;

        function void clear_state();
            listed = '{default: 0};
            count = 0;
            mode = MODE_ASC;
            tie = 1'b0;
            pending.delete();
            errors = 0;
        endfunction

        function bit passes(logic [31:0] nk, logic [31:0] cur);
            if (mode == MODE_ASC && $signed(nk) > $signed(cur))
                return 1;
            if (mode == MODE_DESC && $signed(nk) < $signed(cur))
                return 1;
            if (nk != cur && mode != MODE_EQ)
                return 0;
            return !tie;
        endfunction

        function void place(logic [4:0] s);
            int p;
            p = 0;
            while (p < count && passes(slot_keys[s], slot_keys[order_slots[p]]))
                p++;
            for (int i = count; i > p; i--)
                order_slots[i] = order_slots[i-1];
            order_slots[p] = s;
            count++;
            listed[s] = 1;
        endfunction

        function void unplace(logic [4:0] s);
            int p;
            p = 0;
            while (p < count && order_slots[p] != s)
                p++;
            for (int i = p; i + 1 < count; i++)
                order_slots[i] = order_slots[i+1];
            count--;
            listed[s] = 0;
        endfunction

        function void note_command(logic [2:0] op, logic [4:0] s, logic [31:0] k);
            logic [1:0] st;
            st = ST_OK;
            case (op)
                OP_INSERT:
                    if (listed[s])
                        st = ST_LISTED;
                    else
                    begin
                        slot_keys[s] = k;
                        place(s);
                    end
                OP_REKEY, OP_REMOVE:
                    if (!listed[s])
                        st = ST_NOT_LISTED;
                    else
                    begin
                        unplace(s);
                        if (op == OP_REKEY)
                        begin
                            slot_keys[s] = k;
                            place(s);
                        end
                    end
                OP_WALK:
                    if (count > 0)
                    begin
                        for (int i = 0; i < count; i++)
                            pending.push_back({ST_OK, order_slots[i],
                                slot_keys[order_slots[i]], 1'b1, 1'(i == count - 1)});
                        return;
                    end
                OP_CLEAR:
                begin
                    listed = '{default: 0};
                    count = 0;
                end
                default: ;
            endcase
            pending.push_back({st, 5'd0, 32'd0, 1'b0, 1'b1});
        endfunction

        function void check_result(list_result_t got);
            list_result_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status exp %0d got %0d", exp.status, got.status);
                errors++;
            end
            if (got.slot !== exp.slot)
            begin
                $error("out_slot exp %0d got %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.key !== exp.key)
            begin
                $error("out_key exp %0d got %0d", $signed(exp.key), $signed(got.key));
                errors++;
            end
            if (got.valid !== exp.valid)
            begin
                $error("entry_valid exp %0d got %0d", exp.valid, got.valid);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last exp %0d got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [4:0]  node_slot;
    logic signed [31:0] order_key;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [4:0]  out_slot;
    logic signed [31:0] out_key;
    logic        entry_valid;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [1:0]  cfg_data;

    list_scoreboard board;
    int  cycles;
    bit  calm;
    bit  hold_off;

    sorted_priority_list #(.SLOTS(NUM_SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .node_slot(node_slot), .order_key(order_key),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .out_slot(out_slot), .out_key(out_key),
        .entry_valid(entry_valid), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // check each result transfer
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_result({status, out_slot, out_key, entry_valid, last});

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // valid stays high after a transfer; drain drops it, and so may the next command
    task automatic send_command(logic [2:0] op, logic [4:0] s, logic [31:0] k);
        if (!calm)
            while ($urandom_range(99) < 6)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        operation <= op;
        node_slot <= s;
        order_key <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_command(op, s, k);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        // every result is in; wait on with in_valid low before returning
        repeat (120)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_COMPARE_MODE)
            board.mode = val;
        else
            board.tie = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return $urandom_range(6) - 3;
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [2:0] op;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                op = OP_INSERT;
            else if (r < 55)
                op = OP_REKEY;
            else if (r < 72)
                op = OP_REMOVE;
            else if (r < 90)
                op = OP_WALK;
            else if (r < 94)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(7));
            send_command(op, 5'($urandom), pick_key());
        end
    endtask

    initial
    begin
        board = new();
        board.clear_state();
        cycles = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_INSERT;
        node_slot = '0;
        order_key = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COMPARE_MODE;
        cfg_data = MODE_ASC;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        repeat (2)
            @(negedge clk);

        // directed: extremes, ties, every operation and status
        send_command(OP_WALK, 5'd0, 32'd0);
        send_command(OP_REMOVE, 5'd3, 32'd0);
        send_command(OP_REKEY, 5'd31, 32'd1);
        send_command(OP_INSERT, 5'd31, 32'h7fff_ffff);
        send_command(OP_INSERT, 5'd0, 32'h8000_0000);
        send_command(OP_INSERT, 5'd5, 32'd0);
        send_command(OP_INSERT, 5'd6, 32'd0);
        send_command(OP_INSERT, 5'd5, 32'd9);
        send_command(OP_WALK, 5'd0, 32'd0);
        send_command(OP_REKEY, 5'd0, 32'hffff_ffff);
        send_command(OP_REMOVE, 5'd31, 32'd0);
        send_command(OP_WALK, 5'd0, 32'd0);
        send_command(3'd5, 5'd1, 32'd1);
        send_command(3'd7, 5'd2, 32'd2);
        send_command(OP_CLEAR, 5'd0, 32'd0);
        send_command(OP_WALK, 5'd0, 32'd0);
        drain();

        // sweep every mode and tie setting
        for (int m = 0; m < 4; m++)
            for (int t = 0; t < 2; t++)
            begin
                write_reg(REG_COMPARE_MODE, 2'(m));
                write_reg(REG_TIE_FIRST, 2'(t));
                calm = (m == 1 && t == 0);
                random_phase(34);
                send_command(OP_WALK, 5'd0, 32'd0);
                drain();
            end
        calm = 1'b0;

        // fill the list, then hold the receiver so the block backs up
        for (int s = 0; s < NUM_SLOTS; s++)
            send_command(OP_INSERT, 5'(s), pick_key());
        hold_off = 1'b1;
        fork
            begin
                repeat (400)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 8; i++)
                    send_command(OP_WALK, 5'd0, 32'd0);
                drain();
            end
        join
        random_phase(20);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
design/spl_pkg.sv
design/spl_front.sv
design/spl_back.sv
design/sorted_priority_list.sv
sim/tb_sorted_priority_list.sv
